// ===== hw/rtl/lswg_pkg.sv =====
package lswg_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_PHASE_SPEED = 3'd0;
  localparam logic [2:0] REG_SCROLL_BASE_SPEED = 3'd1;
  localparam logic [2:0] REG_ZOOM_AMPLITUDE    = 3'd2;
  localparam logic [2:0] REG_LINE_PHASE_STEP   = 3'd3;
  localparam logic [2:0] REG_VERTICAL_STEP     = 3'd4;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int LINE_W      = 10;
  localparam int VOFF_W      = 24;
  localparam int WORD_W      = 32;
  localparam int SINE_W      = 18;
  localparam int ANGLE_W     = 12;

  localparam int DEF_LINES        = 224;
  localparam int DEF_SINE_ENTRIES = 4096;

  localparam logic [31:0] ONE_FX     = 32'h0001_0000;
  localparam logic [32:0] DIVIDEND   = 33'h1_0000_0000;
  localparam logic [5:0]  DIV_STEPS  = 6'd33;

  // shift-subtract division, used only while building the sine table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(65536*sin(2*pi*k/n)) by a first-quadrant taylor series in 2^-30
  function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned k, int unsigned n);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    m = 64'(4 * k);
    q = udiv64(m, 64'(n));
    rem = m - q * 64'(n);
    if (q[0]) begin
      rem = 64'(n) - rem;
    end
    x = udiv64(64'd1686629713 * rem, 64'(n));
    sum = $signed(x);
    term = x;
    for (int i = 1; i <= 12; i++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv64(term, 64'((2 * i) * (2 * i + 1)));
      if (i % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd8192) >> 14;
    return (q >= 64'd2) ? -SINE_W'(r) : SINE_W'(r);
  endfunction

endpackage

// ===== hw/rtl/lswg_in_if.sv =====
interface lswg_in_if;
  logic valid;
  logic ready;
  logic line_tick;
  logic restart;

  modport source (output valid, output line_tick, output restart, input ready);
  modport sink   (input valid, input line_tick, input restart, output ready);
endinterface

// ===== hw/rtl/lswg_out_if.sv =====
interface lswg_out_if;
  logic                valid;
  logic                ready;
  logic [9:0]          line_index;
  logic signed [31:0]  h_scroll;
  logic [23:0]         v_offset;
  logic signed [31:0]  zoom;
  logic                divide_fault;
  logic                last_line;

  modport source (output valid, output line_index, output h_scroll, output v_offset,
                  output zoom, output divide_fault, output last_line, input ready);
  modport sink   (input valid, input line_index, input h_scroll, input v_offset,
                  input zoom, input divide_fault, input last_line, output ready);
endinterface

// ===== hw/rtl/lswg_cfg_if.sv =====
interface lswg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/line_scroll_wave_generator.sv =====
// Line scroll wave generator: one scroll/zoom table entry per scanline.
// in_ch   : line ticks (line_tick, restart); an item with neither bit set is
//           taken and produces nothing.
// out_ch  : one entry per processed line: line_index, h_scroll, v_offset,
//           zoom, divide_fault, last_line.
// cfg_ch  : register writes, index 0..4, always ready; write only while idle.
// Flow    : a line goes through the sine/offset lookup, the amplitude
//           multiply, the divisor sum, then a radix-2 restoring divider
//           that forms 2^32/divisor one quotient bit per cycle (skipped
//           when the divisor is zero), then the result register. A new
//           line is taken only in idle, once the last one has been loaded
//           into the output register, so one line is worked on at a time.
// Reset   : control, config and frame registers clear; the per-line offset
//           memory is then swept to zero, one entry a cycle, with the input
//           held not ready.
// Stalls  : a finished entry waits in the output register; the next line may
//           be taken and worked on meanwhile, and it holds in its last step
//           until the output register is free.
module line_scroll_wave_generator #(
  parameter int LINES        = lswg_pkg::DEF_LINES,
  parameter int SINE_ENTRIES = lswg_pkg::DEF_SINE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  lswg_in_if.sink    in_ch,
  lswg_out_if.source out_ch,
  lswg_cfg_if.sink   cfg_ch
);

  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SW = $clog2(SINE_ENTRIES);
  localparam logic [10:0] LINES_C = 11'(LINES);
  localparam logic [9:0]  LAST_C  = 10'(LINES - 1);
  localparam int SINE_W_L  = lswg_pkg::SINE_W;
  localparam int ANGLE_W_L = lswg_pkg::ANGLE_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r;

  // config registers
  logic [31:0] fp_speed_r, sb_speed_r, amp_r, step_r;
  logic [23:0] vstep_r;

  // frame state
  logic [31:0] frame_phase_r, scroll_base_r, running_phase_r;
  logic [9:0]  line_count_r;
  logic [9:0]  line_r;
  logic [LW-1:0] clr_cnt_r;

  // datapath
  logic signed [SINE_W_L-1:0] sin_r;
  logic [23:0] vrd_r, voff_r;
  logic signed [49:0] prod_r;
  logic [31:0] mag_r;
  logic        neg_r, fault_r;
  logic [31:0] rem_r;
  logic [32:0] quo_r;
  logic [5:0]  cnt_r;

  // output register
  logic        ovalid_r;
  logic [9:0]  o_line_r;
  logic [31:0] o_hs_r, o_zoom_r;
  logic [23:0] o_voff_r;
  logic        o_fault_r, o_last_r;

  // memories
  logic signed [SINE_W_L-1:0] sine_rom [SINE_ENTRIES];
  logic [23:0] vmem [LINES];

  genvar g;
  generate
    for (g = 0; g < SINE_ENTRIES; g++) begin : g_rom
      localparam logic signed [SINE_W_L-1:0] ENTRY =
        lswg_pkg::sine_entry(g, SINE_ENTRIES);
      assign sine_rom[g] = ENTRY;
    end
  endgenerate

  // line selection at input transfer
  logic       in_xfer, work;
  logic [9:0] line_sel;
  logic [10:0] line_inc;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign work = in_ch.line_tick || in_ch.restart;
  always_comb begin
    line_sel = in_ch.restart ? 10'd0 : line_count_r;
    if ({1'b0, line_sel} >= LINES_C) begin
      line_sel = 10'd0;
    end
    line_inc = {1'b0, line_sel} + 11'd1;
  end

  // sine index from the angle bits of the running phase
  logic [ANGLE_W_L+12:0] idx_full;
  assign idx_full = ({13'd0, running_phase_r[27:16]} * 25'(SINE_ENTRIES)) >> 12;

  // divisor
  logic [31:0] divisor;
  assign divisor = amp_r + lswg_pkg::ONE_FX + prod_r[47:16];

  // one restoring divide step
  logic [32:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem_r, quo_r[32]};
  assign qbit = (rem_sh >= {1'b0, mag_r});

  // final zoom and scroll
  logic [31:0] zoom_fin, hs_t, hs_fin;
  logic        out_free;
  assign zoom_fin = fault_r ? 32'd0 : (neg_r ? (32'd0 - quo_r[31:0]) : quo_r[31:0]);
  assign hs_t = lswg_pkg::ONE_FX - zoom_fin;
  assign hs_fin = (hs_t << 7) + (hs_t << 5) + (hs_t << 4) + scroll_base_r;
  assign out_free = !ovalid_r || out_ch.ready;

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_speed_r <= '0;
      sb_speed_r <= '0;
      amp_r      <= '0;
      step_r     <= '0;
      vstep_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lswg_pkg::REG_FRAME_PHASE_SPEED: fp_speed_r <= cfg_ch.data;
        lswg_pkg::REG_SCROLL_BASE_SPEED: sb_speed_r <= cfg_ch.data;
        lswg_pkg::REG_ZOOM_AMPLITUDE:    amp_r      <= cfg_ch.data;
        lswg_pkg::REG_LINE_PHASE_STEP:   step_r     <= cfg_ch.data;
        lswg_pkg::REG_VERTICAL_STEP:     vstep_r    <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  // sequencer and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      frame_phase_r   <= '0;
      scroll_base_r   <= '0;
      running_phase_r <= '0;
      line_count_r    <= '0;
      ovalid_r        <= 1'b0;
      cnt_r           <= '0;
    end else begin
      // output valid: set when an entry is loaded, cleared on its transfer
      if (state_r == S_FIN && out_free) begin
        ovalid_r <= 1'b1;
      end else if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LW'(LINES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && work) begin
            line_r <= line_sel;
            if (line_sel == 10'd0) begin
              running_phase_r <= frame_phase_r + step_r;
              frame_phase_r   <= frame_phase_r + fp_speed_r;
              scroll_base_r   <= scroll_base_r + sb_speed_r;
            end else begin
              running_phase_r <= running_phase_r + step_r;
            end
            line_count_r <= (line_inc >= LINES_C) ? 10'd0 : line_inc[9:0];
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (divisor == 32'd0) begin
            state_r <= S_FIN;
          end else begin
            cnt_r   <= lswg_pkg::DIV_STEPS;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // table lookups, multiply, divider datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOOK: begin
        sin_r <= sine_rom[idx_full[SW-1:0]];
        vrd_r <= vmem[line_r[LW-1:0]];
      end
      S_MUL: begin
        prod_r <= $signed(amp_r) * sin_r;
        voff_r <= vrd_r + vstep_r;
      end
      S_SUM: begin
        neg_r   <= divisor[31];
        mag_r   <= divisor[31] ? (32'd0 - divisor) : divisor;
        fault_r <= (divisor == 32'd0);
        rem_r   <= '0;
        quo_r   <= (divisor == 32'd0) ? 33'd0 : lswg_pkg::DIVIDEND;
      end
      S_DIV: begin
        rem_r <= qbit ? 32'(rem_sh - {1'b0, mag_r}) : rem_sh[31:0];
        quo_r <= {quo_r[31:0], qbit};
      end
      default: ;
    endcase
  end

  // per-line offset memory: clearing sweep, then one write per line
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      vmem[clr_cnt_r] <= '0;
    end else if (state_r == S_SUM) begin
      vmem[line_r[LW-1:0]] <= voff_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      o_line_r  <= line_r;
      o_hs_r    <= hs_fin;
      o_voff_r  <= voff_r;
      o_zoom_r  <= zoom_fin;
      o_fault_r <= fault_r;
      o_last_r  <= (line_r == LAST_C);
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.line_index   = o_line_r;
  assign out_ch.h_scroll     = o_hs_r;
  assign out_ch.v_offset     = o_voff_r;
  assign out_ch.zoom         = o_zoom_r;
  assign out_ch.divide_fault = o_fault_r;
  assign out_ch.last_line    = o_last_r;

  // checks
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_fault |-> out_ch.zoom == 32'd0)
    else $error("fault entry with nonzero zoom");

  a_last_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_line |-> out_ch.line_index == LAST_C)
    else $error("last_line on wrong line");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r != 6'd0)
    else $error("divider ran past its step count");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |-> {1'b0, line_r} < LINES_C)
    else $error("line index out of range");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int NUM_LINES   = lswg_pkg::DEF_LINES;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [9:0]  line_index;
    logic [31:0] h_scroll;
    logic [23:0] v_offset;
    logic [31:0] zoom;
    logic        divide_fault;
    logic        last_line;
  } line_entry_t;

  logic clk;
  logic rst_n;

  lswg_in_if  in_ch();
  lswg_out_if out_ch();
  lswg_cfg_if cfg_ch();

  line_scroll_wave_generator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predictor state
  int          sine_lut [lswg_pkg::DEF_SINE_ENTRIES];
  logic [31:0] phase_speed, base_speed, amplitude, phase_step;
  logic [23:0] vert_step;
  logic [31:0] frame_phase, scroll_base, line_phase;
  logic [9:0]  next_line;
  logic [23:0] line_offsets [NUM_LINES];

  line_entry_t pending_entries[$];
  int errors;
  int sent_lines;
  int checked_lines;
  int fault_lines;
  int frame_ends;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // integer sine, 2^-30 taylor series in the first quadrant, rounded to 16.16
  function automatic int sine_value(int unsigned k, int unsigned n);
    longint unsigned quad, rem, x, term, rounded;
    longint          acc;
    quad = (4 * k) / n;
    rem  = (4 * k) % n;
    if (quad[0]) begin
      rem = n - rem;
    end
    x = (64'd1686629713 * rem) / n;
    acc = x;
    term = x;
    for (int i = 1; i <= 12; i++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (longint'(acc) + 8192) >> 14;
    return (quad >= 2) ? -int'(rounded) : int'(rounded);
  endfunction

  function automatic void clear_model();
    phase_speed = '0;
    base_speed  = '0;
    amplitude   = '0;
    phase_step  = '0;
    vert_step   = '0;
    frame_phase = '0;
    scroll_base = '0;
    line_phase  = '0;
    next_line   = '0;
    foreach (line_offsets[i]) line_offsets[i] = '0;
  endfunction

  // work out the table entry one accepted tick produces
  function automatic void predict_line(logic tick, logic restart);
    logic [9:0]  line;
    logic [11:0] angle;
    longint      product;
    logic [31:0] wobble, divisor, zoom;
    longint      quotient;
    line_entry_t entry;
    if (!tick && !restart) begin
      return;
    end
    line = restart ? 10'd0 : next_line;
    if (line >= NUM_LINES) begin
      line = '0;
    end
    if (line == 0) begin
      line_phase  = frame_phase;
      frame_phase = frame_phase + phase_speed;
      scroll_base = scroll_base + base_speed;
    end
    line_phase = line_phase + phase_step;
    angle = line_phase[27:16];
    product = longint'($signed(amplitude)) * longint'(sine_lut[angle]);
    wobble = 32'(product >>> 16);
    divisor = amplitude + lswg_pkg::ONE_FX + wobble;
    entry.divide_fault = (divisor == 0);
    if (divisor == 0) begin
      zoom = '0;
    end else begin
      quotient = 64'sh1_0000_0000 / longint'($signed(divisor));
      zoom = quotient[31:0];
    end
    line_offsets[line] = line_offsets[line] + vert_step;
    entry.line_index = line;
    entry.v_offset   = line_offsets[line];
    entry.zoom       = zoom;
    entry.h_scroll   = (lswg_pkg::ONE_FX - zoom) * 32'hB0 + scroll_base;
    entry.last_line  = (line == NUM_LINES - 1);
    next_line = (line + 1 >= NUM_LINES) ? 10'd0 : line + 10'd1;
    pending_entries.push_back(entry);
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_line(logic tick, logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.line_tick <= tick;
    in_ch.restart   <= restart;
    do @(posedge clk); while (!in_ch.ready);
    predict_line(tick, restart);
    if (tick || restart) begin
      sent_lines++;
    end
  endtask

  // wait for every entry, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
  endtask

  // write all five registers back to back
  task automatic write_regs(logic [31:0] fps, logic [31:0] sbs, logic [31:0] amp,
                            logic [31:0] lps, logic [23:0] vs);
    logic [31:0] vals [5];
    logic [2:0]  idx [5];
    vals = '{fps, sbs, amp, lps, {8'h00, vs}};
    idx  = '{lswg_pkg::REG_FRAME_PHASE_SPEED, lswg_pkg::REG_SCROLL_BASE_SPEED,
             lswg_pkg::REG_ZOOM_AMPLITUDE, lswg_pkg::REG_LINE_PHASE_STEP,
             lswg_pkg::REG_VERTICAL_STEP};
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        lswg_pkg::REG_FRAME_PHASE_SPEED: phase_speed = vals[i];
        lswg_pkg::REG_SCROLL_BASE_SPEED: base_speed  = vals[i];
        lswg_pkg::REG_ZOOM_AMPLITUDE:    amplitude   = vals[i];
        lswg_pkg::REG_LINE_PHASE_STEP:   phase_step  = vals[i];
        lswg_pkg::REG_VERTICAL_STEP:     vert_step   = vals[i][23:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  // registers at reset, no-op items, plain ticks and restarts
  task automatic test_reset_defaults();
    send_line(1'b0, 1'b0);
    send_line(1'b1, 1'b0);
    send_line(1'b1, 1'b0);
    send_line(1'b0, 1'b0);
    send_line(1'b1, 1'b1);
    send_line(1'b0, 1'b1);
    send_line(1'b1, 1'b0);
    drain();
  endtask

  // zero divisor faults, a divisor of minus one wraps to zero, then a small positive divisor
  task automatic test_divisor_corners();
    write_regs(32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 24'hFFFFFF);
    send_line(1'b0, 1'b1);
    send_line(1'b1, 1'b0);
    drain();
    write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_FFFF, 32'h0, 24'h000001);
    send_line(1'b0, 1'b1);
    send_line(1'b1, 1'b0);
    drain();
    write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0001, 32'h0, 24'h800000);
    send_line(1'b1, 1'b1);
    send_line(1'b1, 1'b0);
    drain();
  endtask

  // extreme amplitudes and steps over a few lines
  task automatic test_extremes();
    write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) send_line(1'b1, 1'b0);
    drain();
    write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'h0);
    for (int i = 0; i < 4; i++) send_line(1'b1, 1'b0);
    drain();
  endtask

  // random frames under one idling mode and two register settings
  task automatic test_random_lines(int idle_pct, int stall_pct, int lines);
    int done;
    int r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int ph = 0; ph < 2; ph++) begin
      write_regs(pick_word(), pick_word(), pick_word(), pick_word(), 24'(pick_word()));
      done = 0;
      while (done < lines / 2) begin
        r = $urandom_range(99);
        if (r < 5) begin
          send_line(1'($urandom), 1'b1);
          done++;
        end else if (r < 10) begin
          send_line(1'b0, 1'b0);
        end else begin
          send_line(1'b1, 1'b0);
          done++;
        end
      end
      drain();
    end
  endtask

  // check each entry against the oldest prediction
  always @(posedge clk) begin
    line_entry_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_entries.size() == 0) begin
        $error("entry with nothing expected, line_index %0d", out_ch.line_index);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        checked_lines++;
        if (out_ch.divide_fault) fault_lines++;
        if (out_ch.last_line) frame_ends++;
        if (out_ch.line_index !== want.line_index) begin
          $error("line_index expected %0d got %0d", want.line_index, out_ch.line_index);
          errors++;
        end
        if (out_ch.h_scroll !== want.h_scroll) begin
          $error("h_scroll expected %h got %h", want.h_scroll, out_ch.h_scroll);
          errors++;
        end
        if (out_ch.v_offset !== want.v_offset) begin
          $error("v_offset expected %h got %h", want.v_offset, out_ch.v_offset);
          errors++;
        end
        if (out_ch.zoom !== want.zoom) begin
          $error("zoom expected %h got %h", want.zoom, out_ch.zoom);
          errors++;
        end
        if (out_ch.divide_fault !== want.divide_fault) begin
          $error("divide_fault expected %b got %b", want.divide_fault, out_ch.divide_fault);
          errors++;
        end
        if (out_ch.last_line !== want.last_line) begin
          $error("last_line expected %b got %b", want.last_line, out_ch.last_line);
          errors++;
        end
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sent_lines     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.line_tick = 1'b0;
    in_ch.restart   = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = lswg_pkg::REG_FRAME_PHASE_SPEED;
    cfg_ch.data     = '0;
    for (int k = 0; k < lswg_pkg::DEF_SINE_ENTRIES; k++) begin
      sine_lut[k] = sine_value(k, lswg_pkg::DEF_SINE_ENTRIES);
    end
    clear_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_divisor_corners();
    test_extremes();
    test_random_lines(24, 55, 300);
    test_random_lines(55, 24, 300);
    test_random_lines(0, 0, 300);

    $display("covered %0d lines, %0d checked, %0d divide faults, %0d frame ends",
             sent_lines, checked_lines, fault_lines, frame_ends);
    if (errors == 0 && pending_entries.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
